@@ src/nsdq_pkg.sv @@
// Shared widths, constants, coefficient tables and helpers for the dither quantizer.
package nsdq_pkg;

    localparam int SAMPLE_W  = 24;
    localparam int CHAN_W    = 3;
    localparam int OUT_W     = 16;
    localparam int RATE_W    = 2;
    localparam int HIST_TAPS = 4;
    localparam int TAP_W     = 2;
    localparam int FB_W      = 25;
    localparam int ER_W      = 18;
    localparam int COEF_W    = 17;
    localparam int GAIN_W    = 16;
    localparam int MA_W      = 33;
    localparam int MB_W      = 28;
    localparam int PROD_W    = MA_W + MB_W;
    localparam int SCALE_W   = 42;
    localparam int ACC_W     = 42;
    localparam int S_W       = 34;
    localparam int S2_W      = 35;
    localparam int DITH_W    = 17;
    localparam int SEED_W    = 32;
    localparam int SIL_W     = 10;
    localparam int STEP_W    = 4;

    typedef logic signed [COEF_W-1:0] t_coef;

    localparam logic [RATE_W-1:0] RATE_48K     = 2'd0;
    localparam logic [RATE_W-1:0] RATE_44K     = 2'd1;
    localparam logic [RATE_W-1:0] RATE_LOWPASS = 2'd2;

    localparam logic [SIL_W-1:0] SILENCE_MAX = 10'd960;
    localparam logic [SIL_W-1:0] MUTE_DITHER = 10'd16;
    localparam logic [SIL_W-1:0] MUTE_CLEAR  = 10'd64;

    localparam logic [SEED_W-1:0]     SEED_RESET = 32'd22222;
    localparam logic [SEED_W-1:0]     LCG_ADD    = 32'd907633515;
    localparam logic signed [MB_W-1:0] LCG_MUL   = 28'sd96314165;

    localparam logic [GAIN_W-1:0] GAIN_STD     = 16'd32753;
    localparam logic [GAIN_W-1:0] GAIN_LOWPASS = 16'd32765;

    localparam logic signed [FB_W-1:0] FILT_MAX  = 25'sd16777215;
    localparam logic signed [FB_W-1:0] FILT_MIN  = -25'sd16777216;
    localparam logic signed [ER_W-1:0] ERR_LIMIT = 18'sd98304;

    // Error taps first, then feedback taps; Q2.14.
    localparam t_coef COEF_48K [8] = '{17'sd36658, -17'sd12024, -17'sd2050, -17'sd9884,
                                       17'sd14795, 17'sd190, -17'sd9590, -17'sd4212};
    localparam t_coef COEF_44K [8] = '{17'sd36145, -17'sd7710, -17'sd4152, -17'sd10181,
                                       17'sd17346, 17'sd1108, -17'sd9919, -17'sd4486};
    localparam t_coef COEF_UNITY   = 17'sd16384;

    function automatic t_coef coef_of(input logic [RATE_W-1:0] rs, input logic [2:0] k);
        t_coef v;
        case (rs)
            RATE_48K: v = COEF_48K[k];
            RATE_44K: v = COEF_44K[k];
            default:  v = (k == 3'd0) ? COEF_UNITY : '0;
        endcase
        return v;
    endfunction

    function automatic logic [GAIN_W-1:0] gain_of(input logic [RATE_W-1:0] rs);
        logic [GAIN_W-1:0] g;
        case (rs)
            RATE_48K, RATE_44K: g = GAIN_STD;
            default:            g = GAIN_LOWPASS;
        endcase
        return g;
    endfunction

endpackage

@@ src/noise_shaped_dither_quantizer.sv @@
// Top level: per-channel noise-shaped, dithered 24-to-16-bit quantizer.
// An item is accepted only while the block is idle. After acceptance come eleven products
// (two random draws, the gain scaling and eight filter taps), one per cycle through a single
// shared 33x28-bit multiplier, then the error, sum, round and write steps for rounding,
// clamping and history write-back, and a done state that hands the result to the output
// register.
// The result waits in that register, so a further item is accepted while it is unread, and
// the block then stalls at its end only while the previous result is still held.
// Filter history is kept in a memory with one row per channel, with separate valid bits for
// the feedback and error halves of each row, so reset and long-silence clearing need no pass over the memory.
module noise_shaped_dither_quantizer #(
    parameter int MAX_CHANNELS = 8
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_valid,
    output logic                                    o_ready,
    input  logic signed [nsdq_pkg::SAMPLE_W-1:0]    i_sample,
    input  logic        [nsdq_pkg::CHAN_W-1:0]      i_channel,
    input  logic                                    i_frame_last,
    input  logic                                    i_call_start,
    output logic                                    o_valid,
    input  logic                                    i_ready,
    output logic signed [nsdq_pkg::OUT_W-1:0]       o_out_sample,
    input  logic                                    i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  logic        [nsdq_pkg::RATE_W-1:0]      i_cfg_data
);
    import nsdq_pkg::*;

    localparam int ADDR_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int EXT_W  = ADDR_W + CHAN_W;
    localparam int ROW_W  = HIST_TAPS * (FB_W + ER_W);
    localparam int ER_OFS = HIST_TAPS * FB_W;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_BUSY = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    localparam logic [STEP_W-1:0] OP_LCG1  = 4'd0;
    localparam logic [STEP_W-1:0] OP_SCALE = 4'd1;
    localparam logic [STEP_W-1:0] OP_BTAP0 = 4'd2;
    localparam logic [STEP_W-1:0] OP_BTAP3 = 4'd5;
    localparam logic [STEP_W-1:0] OP_ATAP0 = 4'd6;
    localparam logic [STEP_W-1:0] OP_ATAP3 = 4'd9;
    localparam logic [STEP_W-1:0] OP_LCG2  = 4'd10;
    localparam logic [STEP_W-1:0] ST_ERR   = 4'd11;
    localparam logic [STEP_W-1:0] ST_SUM   = 4'd12;
    localparam logic [STEP_W-1:0] ST_ROUND = 4'd13;
    localparam logic [STEP_W-1:0] ST_WRITE = 4'd14;

    localparam logic signed [S2_W:0] T_MAX = 36'sd2147418112;
    localparam logic signed [S2_W:0] T_MIN = -36'sd2147483648;

    // Control state.
    logic [1:0]              r_state;
    logic [STEP_W-1:0]       r_step;
    logic [SEED_W-1:0]       r_seed;
    logic [SEED_W-1:0]       r_u1;
    logic [SIL_W-1:0]        r_silence;
    logic                    r_frame_silent;
    logic [MAX_CHANNELS-1:0] r_fb_valid;
    logic [MAX_CHANNELS-1:0] r_er_valid;
    logic                    r_fb_ok;
    logic                    r_er_ok;
    logic                    r_out_valid;
    logic [RATE_W-1:0]       r_rate;

    // Item payload and datapath.
    logic signed [SAMPLE_W-1:0] r_x;
    logic [ADDR_W-1:0]          r_addr;
    logic                       r_ch_ok;
    logic                       r_last;
    logic                       r_muted;
    logic [ROW_W-1:0]           r_row;
    logic signed [PROD_W-1:0]   r_prod;
    logic signed [ACC_W-1:0]    r_acc;
    logic signed [S_W-1:0]      r_s;
    logic signed [FB_W-1:0]     r_err;
    logic signed [S2_W-1:0]     r_s2;
    logic signed [DITH_W-1:0]   r_dith;
    logic signed [OUT_W-1:0]    r_si;
    logic signed [OUT_W-1:0]    r_out;

    logic [ROW_W-1:0] r_mem [MAX_CHANNELS];

    logic                     w_accept;
    logic [EXT_W-1:0]         w_ch_ext;
    logic                     w_ch_ok;
    logic [ADDR_W-1:0]        w_addr;
    logic                     w_clear;
    logic [RATE_W-1:0]        w_rs;
    logic signed [FB_W-1:0]   w_fb [HIST_TAPS];
    logic signed [ER_W-1:0]   w_er [HIST_TAPS];
    logic [STEP_W-1:0]        w_boff;
    logic [STEP_W-1:0]        w_aoff;
    logic [TAP_W-1:0]         w_bj;
    logic [TAP_W-1:0]         w_aj;
    logic [STEP_W-1:0]        w_cons;
    logic signed [MA_W-1:0]   w_ma;
    logic signed [MB_W-1:0]   w_mb;
    logic signed [PROD_W-1:0] w_prod;
    logic [SEED_W-1:0]        w_lcg;
    logic signed [SCALE_W-1:0] w_scale_rnd;
    logic signed [ACC_W:0]    w_acc_rnd;
    logic signed [ACC_W:0]    w_acc_sh;
    logic signed [FB_W-1:0]   w_err;
    logic signed [S2_W-1:0]   w_s2;
    logic signed [SEED_W:0]   w_udiff;
    logic signed [SEED_W:0]   w_udiff_sh;
    logic signed [DITH_W-1:0] w_dith;
    logic signed [S2_W:0]     w_t_sum;
    logic signed [31:0]       w_t;
    logic signed [32:0]       w_t_rnd;
    logic signed [OUT_W-1:0]  w_si;
    logic signed [S2_W:0]     w_e_diff;
    logic signed [ER_W-1:0]   w_e;
    logic [ROW_W-1:0]         w_new_row;
    logic                     w_fsil;
    logic                     w_out_free;

    assign o_ready      = (r_state == ST_IDLE);
    assign o_valid      = r_out_valid;
    assign o_out_sample = r_out;
    assign o_cfg_ready  = 1'b1;

    assign w_accept   = i_valid && o_ready;
    assign w_ch_ext   = EXT_W'(i_channel);
    assign w_ch_ok    = (w_ch_ext < EXT_W'(MAX_CHANNELS));
    assign w_addr     = w_ch_ext[ADDR_W-1:0];
    assign w_clear    = i_call_start && (r_silence > MUTE_CLEAR);
    assign w_rs       = (r_rate > RATE_LOWPASS) ? RATE_LOWPASS : r_rate;
    assign w_out_free = !r_out_valid || i_ready;

    // History taps of the current channel; a row never written reads as zero, and its feedback taps also once cleared.
    always_comb begin
        for (int j = 0; j < HIST_TAPS; j++) begin
            w_fb[j] = r_fb_ok ? $signed(r_row[j*FB_W +: FB_W]) : '0;
            w_er[j] = r_er_ok ? $signed(r_row[ER_OFS + j*ER_W +: ER_W]) : '0;
        end
    end

    assign w_boff = r_step - OP_BTAP0;
    assign w_aoff = r_step - OP_ATAP0;
    assign w_bj   = w_boff[TAP_W-1:0];
    assign w_aj   = w_aoff[TAP_W-1:0];
    assign w_cons = r_step - 4'd1;

    // Operand selection for the shared multiplier.
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        case (r_step) inside
            OP_LCG1, OP_LCG2: begin
                w_ma = $signed({1'b0, r_seed});
                w_mb = LCG_MUL;
            end
            OP_SCALE: begin
                w_ma = MA_W'(r_x);
                w_mb = MB_W'($signed({1'b0, gain_of(w_rs)}));
            end
            [OP_BTAP0:OP_BTAP3]: begin
                w_ma = MA_W'(w_er[w_bj]);
                w_mb = MB_W'(coef_of(w_rs, {1'b0, w_bj}));
            end
            [OP_ATAP0:OP_ATAP3]: begin
                w_ma = MA_W'(w_fb[w_aj]);
                w_mb = MB_W'(coef_of(w_rs, {1'b1, w_aj}));
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    assign w_prod = w_ma * w_mb;
    assign w_lcg  = r_prod[SEED_W-1:0] + LCG_ADD;

    assign w_scale_rnd = $signed(r_prod[SCALE_W-1:0]) + 42'sd64;

    // Filter sum back to Q.16, saturated.
    assign w_acc_rnd = (ACC_W+1)'(r_acc) + 43'sd8192;
    assign w_acc_sh  = w_acc_rnd >>> 14;
    always_comb begin
        if (w_acc_sh > (ACC_W+1)'(FILT_MAX)) begin
            w_err = FILT_MAX;
        end else if (w_acc_sh < (ACC_W+1)'(FILT_MIN)) begin
            w_err = FILT_MIN;
        end else begin
            w_err = FB_W'(w_acc_sh);
        end
    end

    assign w_s2       = S2_W'(r_s) - S2_W'(r_err);
    assign w_udiff    = $signed({1'b0, r_u1}) - $signed({1'b0, r_seed});
    assign w_udiff_sh = w_udiff >>> 16;
    assign w_dith     = r_muted ? '0 : DITH_W'(w_udiff_sh);

    // Clamp to the 16-bit range in Q.16, then round half up.
    assign w_t_sum = (S2_W+1)'(r_s2) + (S2_W+1)'(r_dith);
    always_comb begin
        if (w_t_sum > T_MAX) begin
            w_t = 32'(T_MAX);
        end else if (w_t_sum < T_MIN) begin
            w_t = 32'(T_MIN);
        end else begin
            w_t = 32'(w_t_sum);
        end
    end
    assign w_t_rnd = 33'(w_t) + 33'sd32768;
    assign w_si    = $signed(w_t_rnd[31:16]);

    assign w_e_diff = (S2_W+1)'($signed({r_si, 16'b0})) - (S2_W+1)'(r_s2);
    always_comb begin
        if (r_muted) begin
            w_e = '0;
        end else if (w_e_diff > (S2_W+1)'(ERR_LIMIT)) begin
            w_e = ERR_LIMIT;
        end else if (w_e_diff < -(S2_W+1)'(ERR_LIMIT)) begin
            w_e = -ERR_LIMIT;
        end else begin
            w_e = ER_W'(w_e_diff);
        end
    end

    // Shifted history row: newest value goes into tap zero.
    always_comb begin
        w_new_row[0 +: FB_W]      = r_err;
        w_new_row[ER_OFS +: ER_W] = w_e;
        for (int j = 1; j < HIST_TAPS; j++) begin
            w_new_row[j*FB_W +: FB_W]          = w_fb[j-1];
            w_new_row[ER_OFS + j*ER_W +: ER_W] = w_er[j-1];
        end
    end

    assign w_fsil = r_frame_silent && (r_x == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_step         <= '0;
            r_seed         <= SEED_RESET;
            r_u1           <= '0;
            r_silence      <= SILENCE_MAX;
            r_frame_silent <= 1'b1;
            r_fb_valid     <= '0;
            r_er_valid     <= '0;
            r_fb_ok        <= 1'b0;
            r_er_ok        <= 1'b0;
            r_out_valid    <= 1'b0;
            r_rate         <= RATE_48K;
        end else begin
            if (i_cfg_valid) begin
                r_rate <= i_cfg_data;
            end
            if ((r_state == ST_DONE) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_state <= ST_BUSY;
                        r_step  <= OP_LCG1;
                        // Long silence at a block start drops every channel's feedback.
                        if (w_clear) begin
                            r_fb_valid <= '0;
                        end
                        r_fb_ok <= w_ch_ok && r_fb_valid[w_addr] && !w_clear;
                        r_er_ok <= w_ch_ok && r_er_valid[w_addr];
                    end
                end
                ST_BUSY: begin
                    if (w_cons == OP_LCG1) begin
                        r_seed <= w_lcg;
                        r_u1   <= w_lcg;
                    end else if (w_cons == OP_LCG2) begin
                        r_seed <= w_lcg;
                    end
                    if (r_step == ST_WRITE) begin
                        r_state <= ST_DONE;
                        if (r_ch_ok) begin
                            r_fb_valid[r_addr] <= 1'b1;
                            r_er_valid[r_addr] <= 1'b1;
                        end
                        if (r_last) begin
                            if (!w_fsil) begin
                                r_silence <= '0;
                            end else if (r_silence < SILENCE_MAX) begin
                                r_silence <= r_silence + 10'd1;
                            end
                            r_frame_silent <= 1'b1;
                        end else begin
                            r_frame_silent <= w_fsil;
                        end
                    end else begin
                        r_step <= r_step + 4'd1;
                    end
                end
                ST_DONE: begin
                    if (w_out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_x     <= i_sample;
            r_addr  <= w_addr;
            r_ch_ok <= w_ch_ok;
            r_last  <= i_frame_last;
            r_muted <= (r_silence > MUTE_DITHER);
            r_acc   <= '0;
        end
        if (r_state == ST_BUSY) begin
            if (r_step <= OP_LCG2) begin
                r_prod <= w_prod;
            end
            case (w_cons) inside
                OP_SCALE:            r_s   <= S_W'(w_scale_rnd >>> 7);
                [OP_BTAP0:OP_BTAP3]: r_acc <= r_acc + ACC_W'(r_prod);
                [OP_ATAP0:OP_ATAP3]: r_acc <= r_acc - ACC_W'(r_prod);
                default: ;
            endcase
            if (r_step == ST_ERR) begin
                r_err <= w_err;
            end
            if (r_step == ST_SUM) begin
                r_s2   <= w_s2;
                r_dith <= w_dith;
            end
            if (r_step == ST_ROUND) begin
                r_si <= w_si;
            end
        end
        if ((r_state == ST_DONE) && w_out_free) begin
            r_out <= r_si;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_row <= r_mem[w_addr];
        end
        if ((r_state == ST_BUSY) && (r_step == ST_WRITE) && r_ch_ok) begin
            r_mem[r_addr] <= w_new_row;
        end
    end

endmodule

@@ src/nsdq_checker.sv @@
// Port-level assertions for the dither quantizer, bound to the top level.
module nsdq_checker (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 i_valid,
    input logic                                 o_ready,
    input logic                                 o_valid,
    input logic                                 i_ready,
    input logic signed [nsdq_pkg::OUT_W-1:0]    o_out_sample
);

    // A result that is not taken stays offered and unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_out_sample)))
        else $error("output item dropped or changed while stalled");

    // The block works on one item at a time.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("input ready right after an item was accepted");

    // A result never appears in the cycle right after an item is taken.
    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !$rose(o_valid))
        else $error("result offered too early");

    // Reset leaves the block idle with no pending result.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (o_ready && !o_valid))
        else $error("block not idle after reset");

endmodule

bind noise_shaped_dither_quantizer nsdq_checker u_nsdq_checker (.*);

@@ sim/tb_noise_shaped_dither_quantizer.sv @@
// Self-checking testbench for the dither quantizer: a directed table, then random stimulus.
`timescale 1ns / 1ps

module tb_noise_shaped_dither_quantizer;
    import nsdq_pkg::*;

    localparam logic [RATE_W-1:0] RATE_SPARE = 2'd3;
    localparam int STALL_LIMIT  = 2000;
    localparam int SETTLE_WAIT  = 24;
    localparam int PHASE_ITEMS  = 400;
    localparam int SHOWN_ERRORS = 10;

    typedef struct {
        logic signed [SAMPLE_W-1:0] sample;
        logic [CHAN_W-1:0]          channel;
        bit                         frame_last;
        bit                         call_start;
    } t_sample_item;

    typedef struct {
        logic signed [SAMPLE_W-1:0] sample;
        logic [CHAN_W-1:0]          channel;
        bit                         frame_last;
        bit                         call_start;
        bit                         known;
        logic signed [OUT_W-1:0]    want;
    } t_probe_row;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_valid;
    logic                       o_ready;
    logic signed [SAMPLE_W-1:0] i_sample;
    logic [CHAN_W-1:0]          i_channel;
    logic                       i_frame_last;
    logic                       i_call_start;
    logic                       o_valid;
    logic                       i_ready;
    logic signed [OUT_W-1:0]    o_out_sample;
    logic                       i_cfg_valid;
    logic                       o_cfg_ready;
    logic [RATE_W-1:0]          i_cfg_data;

    noise_shaped_dither_quantizer dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_sample     (i_sample),
        .i_channel    (i_channel),
        .i_frame_last (i_frame_last),
        .i_call_start (i_call_start),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_out_sample (o_out_sample),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Shadow state of the quantizer, starting from its reset values.
    logic [RATE_W-1:0] rate_sel = RATE_48K;
    logic [SEED_W-1:0] lcg_state = 32'd22222;
    longint            fb_hist [8][4];
    longint            err_hist [8][4];
    int                sil_count = 960;
    bit                frame_quiet = 1'b1;

    // Error taps first, then feedback taps, per filter set.
    longint shaping_coef [3][8] = '{
        '{36658, -12024, -2050, -9884, 14795, 190, -9590, -4212},
        '{36145, -7710, -4152, -10181, 17346, 1108, -9919, -4486},
        '{16384, 0, 0, 0, 0, 0, 0, 0}
    };

    logic signed [OUT_W-1:0] expected_samples [$];
    t_sample_item            stim_q [$];
    logic [RATE_W-1:0]       phase_rates [4] = '{RATE_44K, RATE_LOWPASS, RATE_SPARE, RATE_48K};

    int  fail_count = 0;
    int  items_sent = 0;
    int  results_seen = 0;
    int  history_clears = 0;
    int  rate_writes = 0;
    int  idle_cycles = 0;
    bit  send_calm = 1'b0;
    bit  recv_calm = 1'b0;

    t_probe_row probe_rows [22] = '{
        // Muted after reset with empty history: plain rounding of sample times gain.
        '{24'sd0,        3'd0, 1'b0, 1'b1, 1'b1, 16'sd0},
        '{24'sd8388607,  3'd1, 1'b0, 1'b0, 1'b1, 16'sd32753},
        '{-24'sd8388608, 3'd2, 1'b0, 1'b0, 1'b1, -16'sd32753},
        '{24'sd1,        3'd3, 1'b0, 1'b0, 1'b1, 16'sd0},
        '{-24'sd1,       3'd4, 1'b0, 1'b0, 1'b1, 16'sd0},
        '{24'sd0,        3'd5, 1'b0, 1'b0, 1'b1, 16'sd0},
        '{24'sd8388607,  3'd7, 1'b1, 1'b0, 1'b1, 16'sd32753},
        // The frame above was loud, so dither and error feedback are live from here.
        '{24'sd0,        3'd0, 1'b0, 1'b1, 1'b0, 16'sd0},
        '{24'sd8388607,  3'd0, 1'b0, 1'b0, 1'b0, 16'sd0},
        '{24'sd8388607,  3'd0, 1'b0, 1'b0, 1'b0, 16'sd0},
        '{24'sd8388607,  3'd0, 1'b0, 1'b0, 1'b0, 16'sd0},
        '{-24'sd8388608, 3'd0, 1'b0, 1'b0, 1'b0, 16'sd0},
        '{-24'sd8388608, 3'd0, 1'b0, 1'b0, 1'b0, 16'sd0},
        '{-24'sd8388608, 3'd1, 1'b0, 1'b0, 1'b0, 16'sd0},
        '{24'sd4194304,  3'd2, 1'b0, 1'b0, 1'b0, 16'sd0},
        '{-24'sd4194304, 3'd3, 1'b0, 1'b0, 1'b0, 16'sd0},
        '{24'sd1193046,  3'd6, 1'b0, 1'b0, 1'b0, 16'sd0},
        '{-24'sd255,     3'd7, 1'b1, 1'b0, 1'b0, 16'sd0},
        '{24'sd0,        3'd0, 1'b1, 1'b0, 1'b0, 16'sd0},
        '{24'sd0,        3'd0, 1'b1, 1'b1, 1'b0, 16'sd0},
        '{24'sd5,        3'd5, 1'b1, 1'b0, 1'b0, 16'sd0},
        '{-24'sd8388608, 3'd7, 1'b1, 1'b1, 1'b0, 16'sd0}
    };

    function automatic longint clip(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // Predicts one output sample and advances the shadow state.
    function automatic logic signed [OUT_W-1:0] quantize_sample(input t_sample_item it);
        longint x, s, acc, flt, dith, t, q, e, gain;
        logic [SEED_W-1:0] u1, u2;
        int sel, ch, j;
        bit muted;
        sel = (rate_sel > RATE_LOWPASS) ? 2 : int'(rate_sel);
        gain = (sel == 2) ? 32765 : 32753;
        muted = (sil_count > int'(MUTE_DITHER));
        x = it.sample;
        // Every 3-bit channel index has its own history row with eight channels.
        ch = it.channel;
        if (it.call_start && sil_count > int'(MUTE_CLEAR)) begin
            history_clears++;
            foreach (fb_hist[c, k]) fb_hist[c][k] = 0;
        end
        s = (x * gain + 64) >>> 7;
        acc = 0;
        for (j = 0; j < 4; j++)
            acc += shaping_coef[sel][j] * err_hist[ch][j]
                   - shaping_coef[sel][j + 4] * fb_hist[ch][j];
        flt = clip((acc + 8192) >>> 14, -16777216, 16777215);
        s = s - flt;
        // Both draws advance the generator even when the dither is muted.
        u1 = lcg_state * 32'd96314165 + 32'd907633515;
        u2 = u1 * 32'd96314165 + 32'd907633515;
        lcg_state = u2;
        dith = muted ? 0 : ((longint'({32'd0, u1}) - longint'({32'd0, u2})) >>> 16);
        t = clip(s + dith, longint'(-32768) * 65536, longint'(32767) * 65536);
        q = (t + 32768) >>> 16;
        e = muted ? 0 : clip(q * 65536 - s, -98304, 98304);
        for (j = 3; j > 0; j--) begin
            fb_hist[ch][j] = fb_hist[ch][j - 1];
            err_hist[ch][j] = err_hist[ch][j - 1];
        end
        fb_hist[ch][0] = flt;
        err_hist[ch][0] = e;
        if (x != 0)
            frame_quiet = 1'b0;
        if (it.frame_last) begin
            if (!frame_quiet)
                sil_count = 0;
            else if (sil_count < int'(SILENCE_MAX))
                sil_count++;
            frame_quiet = 1'b1;
        end
        return q[OUT_W-1:0];
    endfunction

    function automatic int draw_gap(inout bit calm);
        if ($urandom_range(0, 39) == 0)
            calm = !calm;
        return calm ? 0 : $urandom_range(0, 19);
    endfunction

    function automatic t_sample_item make_item(input logic signed [SAMPLE_W-1:0] s,
                                               input logic [CHAN_W-1:0] c, input bit l,
                                               input bit st);
        t_sample_item it;
        it.sample = s;
        it.channel = c;
        it.frame_last = l;
        it.call_start = st;
        return it;
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] rand_sample();
        logic signed [SAMPLE_W-1:0] v;
        case ($urandom_range(0, 7))
            0:       v = 24'sh7FFFFF;
            1:       v = 24'sh800000;
            2:       v = '0;
            3:       v = SAMPLE_W'($urandom_range(0, 1023) - 512);
            default: v = SAMPLE_W'($urandom());
        endcase
        return v;
    endfunction

    // Mostly well-formed frames, with silent runs long enough to mute and to clear history.
    task automatic build_phase(input int target);
        int pick, nch, runlen, f, c;
        bit pend_start, blk;
        pend_start = 1'b1;
        while (stim_q.size() < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                nch = $urandom_range(1, 8);
                blk = pend_start || ($urandom_range(0, 3) == 0);
                pend_start = 1'b0;
                for (c = 0; c < nch; c++)
                    stim_q = {stim_q, make_item(rand_sample(), CHAN_W'(c), c == nch - 1,
                                                blk && c == 0)};
            end else if (pick < 88) begin
                runlen = $urandom_range(1, 80);
                nch = $urandom_range(1, 2);
                for (f = 0; f < runlen; f++)
                    for (c = 0; c < nch; c++)
                        stim_q = {stim_q, make_item('0, CHAN_W'(c), c == nch - 1,
                                                    f == 0 && c == 0 && $urandom_range(0, 1))};
                pend_start = $urandom_range(0, 1);
            end else begin
                nch = $urandom_range(1, 8);
                for (c = 0; c < nch; c++)
                    stim_q = {stim_q, make_item(rand_sample(), CHAN_W'($urandom()),
                                                1'($urandom()), 1'($urandom()))};
            end
        end
    endtask

    // Called at a falling edge; returns at the falling edge after the item is taken.
    task automatic send_one(input t_sample_item it, input bit known,
                            input logic signed [OUT_W-1:0] want);
        int gap;
        logic signed [OUT_W-1:0] got;
        gap = draw_gap(send_calm);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_sample <= it.sample;
        i_channel <= it.channel;
        i_frame_last <= it.frame_last;
        i_call_start <= it.call_start;
        i_valid <= 1'b1;
        do @(posedge i_clk); while (!o_ready);
        got = quantize_sample(it);
        expected_samples = {expected_samples, (known ? want : got)};
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic settle();
        i_valid <= 1'b0;
        while (expected_samples.size() != 0) @(negedge i_clk);
        repeat (SETTLE_WAIT) @(negedge i_clk);
    endtask

    task automatic write_rate(input logic [RATE_W-1:0] v);
        i_cfg_data <= v;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        rate_sel = v;
        rate_writes++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && o_ready) || (o_valid && i_ready) || (i_cfg_valid && o_cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("Timeout: no transfer for %0d cycles", STALL_LIMIT);
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    initial begin
        int stall;
        logic signed [OUT_W-1:0] want;
        i_ready = 1'b0;
        wait (i_rst_n);
        @(negedge i_clk);
        forever begin
            stall = draw_gap(recv_calm);
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
            results_seen++;
            if (expected_samples.size() == 0) begin
                fail_count++;
                if (fail_count <= SHOWN_ERRORS)
                    $display("Result %0d: got %0d with no item pending", results_seen,
                             o_out_sample);
            end else begin
                want = expected_samples.pop_front();
                if (o_out_sample !== want) begin
                    fail_count++;
                    if (fail_count <= SHOWN_ERRORS)
                        $display("Result %0d: expected %0d, got %0d", results_seen, want,
                                 o_out_sample);
                end
            end
            @(negedge i_clk);
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_sample = '0;
        i_channel = '0;
        i_frame_last = 1'b0;
        i_call_start = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data = RATE_48K;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (probe_rows[r])
            send_one(make_item(probe_rows[r].sample, probe_rows[r].channel,
                               probe_rows[r].frame_last, probe_rows[r].call_start),
                     probe_rows[r].known, probe_rows[r].want);

        foreach (phase_rates[p]) begin
            settle();
            write_rate(phase_rates[p]);
            build_phase(PHASE_ITEMS);
            while (stim_q.size() != 0)
                send_one(stim_q.pop_front(), 1'b0, '0);
        end
        settle();

        fail_count += expected_samples.size();
        $display("Sent %0d samples and checked %0d results over %0d filter-set writes.",
                 items_sent, results_seen, rate_writes);
        $display("Long-silence history clears seen along the way: %0d.", history_clears);
        if (fail_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

@@ files.f @@
src/nsdq_pkg.sv
src/noise_shaped_dither_quantizer.sv
src/nsdq_checker.sv
sim/tb_noise_shaped_dither_quantizer.sv
